// ===== src/rlsc_pkg.sv =====
// Shared constants, types and helper functions for the run-length string compressor.
package rlsc_pkg;

  localparam int unsigned MAX_LEN = 64;
  localparam int unsigned DEPTH   = 64;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned TLW     = $clog2(MAX_LEN + 1);
  localparam int unsigned CLW     = TLW + 1;

  localparam logic [7:0] ASCII_ZERO = 8'h30;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PUT_CH = 6'b000010,
    S_PUT_TN = 6'b000100,
    S_PUT_ON = 6'b001000,
    S_DECIDE = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;
    logic put_ch;
    logic put_tens;
    logic put_ones;
    logic decide;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic brk;
    logic ge10;
    logic pend_new;
    logic pend_last;
    logic emit_last;
  } stat_t;

  // Tens digit of a run count; runs never reach 100 since MAX_LEN is at most 64.
  function automatic logic [3:0] tens_digit(input logic [TLW-1:0] n);
    logic [3:0] t;
    t = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, n} >= 8'(k * 10)) t = 4'(k);
    end
    return t;
  endfunction

  function automatic logic [3:0] ones_digit(input logic [TLW-1:0] n);
    logic [3:0] t;
    logic [7:0] tx10;
    t    = tens_digit(n);
    tx10 = {1'b0, t, 3'b000} + {3'b000, t, 1'b0};
    return 4'({1'b0, n} - tx10);
  endfunction

endpackage

// ===== src/run_length_string_compressor.sv =====
// Top level of the run-length string compressor: controller plus datapath.
//
//   channel | ports                          | handshake
//   input   | in_char_i, in_last_i           | taken when start && !busy
//   result  | out_char_o, out_last_o         | one cycle, marked by out_valid_o
//
// A byte that extends or opens a run leaves the controller idle; one that ends a run
// keeps it busy while the run's byte and decimal count go into the code store
// through its single write port. The final byte adds the close of the last run,
// a length compare, then one result per cycle for len bytes from the chosen store.
// Reset clears all control state; stores need no clearing.
// The receiver cannot stall: results leave one per cycle while out_valid_o is high.
module run_length_string_compressor (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_char_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);

  rlsc_pkg::cmd_t  cmd;
  rlsc_pkg::stat_t stat;

  rlsc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .in_last_i (in_last_i),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy      (busy)
  );

  rlsc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_char_i  (in_char_i),
    .in_last_i  (in_last_i),
    .stat_o     (stat),
    .out_char_o (out_char_o),
    .out_last_o (out_last_o)
  );

  assign out_valid_o = cmd.emit;

`ifndef ASSERT_OFF
  a_emit_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy)
    else $error("result strobe while not busy");

  a_last_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_last_o) |=> !out_valid_o && !busy)
    else $error("readout did not end after last byte");

  a_emit_after_decide : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(cmd.emit) |-> $past(cmd.decide))
    else $error("readout started without length compare");
`endif

endmodule

// ===== src/rlsc_ctrl.sv =====
// Controller state machine for the run-length string compressor.
module rlsc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           in_last_i,
  input  rlsc_pkg::stat_t stat_i,
  output rlsc_pkg::cmd_t  cmd_o,
  output logic           busy
);

  rlsc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rlsc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      rlsc_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          // close the open run first when the byte breaks it or ends the string
          if (stat_i.brk || in_last_i) state_d = rlsc_pkg::S_PUT_CH;
        end
      end
      rlsc_pkg::S_PUT_CH: begin
        cmd_o.put_ch = 1'b1;
        state_d = stat_i.ge10 ? rlsc_pkg::S_PUT_TN : rlsc_pkg::S_PUT_ON;
      end
      rlsc_pkg::S_PUT_TN: begin
        cmd_o.put_tens = 1'b1;
        state_d = rlsc_pkg::S_PUT_ON;
      end
      rlsc_pkg::S_PUT_ON: begin
        cmd_o.put_ones = 1'b1;
        if (stat_i.pend_new) begin
          state_d = stat_i.pend_last ? rlsc_pkg::S_PUT_CH : rlsc_pkg::S_IDLE;
        end else begin
          state_d = rlsc_pkg::S_DECIDE;
        end
      end
      rlsc_pkg::S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d = rlsc_pkg::S_EMIT;
      end
      rlsc_pkg::S_EMIT: begin
        cmd_o.emit = 1'b1;
        if (stat_i.emit_last) state_d = rlsc_pkg::S_IDLE;
      end
      default: begin
        state_d = rlsc_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != rlsc_pkg::S_IDLE);

endmodule

// ===== src/rlsc_dp.sv =====
// Datapath: text and code stores, run tracking, length compare and readout.
module rlsc_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rlsc_pkg::cmd_t  cmd_i,
  input  logic [7:0]      in_char_i,
  input  logic            in_last_i,
  output rlsc_pkg::stat_t stat_o,
  output logic [7:0]      out_char_o,
  output logic            out_last_o
);

  logic [7:0] text_mem [rlsc_pkg::DEPTH];
  logic [7:0] code_mem [rlsc_pkg::DEPTH];

  logic [rlsc_pkg::TLW-1:0] text_len_q, run_cnt_q, out_len_q;
  logic [rlsc_pkg::CLW-1:0] code_len_q;
  logic [7:0]               run_ch_q, pend_ch_q, text_rd_q, code_rd_q;
  logic                     run_open_q, pend_new_q, pend_last_q, sel_code_q;
  logic [rlsc_pkg::AW-1:0]  idx_q, raddr;

  logic       kept, same, put, code_room;
  logic [7:0] put_data;

  assign kept      = (text_len_q < rlsc_pkg::TLW'(rlsc_pkg::MAX_LEN));
  assign same      = run_open_q && (in_char_i == run_ch_q);
  assign put       = cmd_i.put_ch || cmd_i.put_tens || cmd_i.put_ones;
  assign code_room = (code_len_q < rlsc_pkg::CLW'(rlsc_pkg::DEPTH));

  always_comb begin
    if (cmd_i.put_ch) begin
      put_data = run_ch_q;
    end else if (cmd_i.put_tens) begin
      put_data = rlsc_pkg::ASCII_ZERO + {4'd0, rlsc_pkg::tens_digit(run_cnt_q)};
    end else begin
      put_data = rlsc_pkg::ASCII_ZERO + {4'd0, rlsc_pkg::ones_digit(run_cnt_q)};
    end
  end

  assign stat_o.brk       = kept && run_open_q && (in_char_i != run_ch_q);
  assign stat_o.ge10      = (run_cnt_q >= rlsc_pkg::TLW'(10));
  assign stat_o.pend_new  = pend_new_q;
  assign stat_o.pend_last = pend_last_q;
  assign stat_o.emit_last = ({1'b0, idx_q} == (out_len_q - rlsc_pkg::TLW'(1)));

  assign raddr = cmd_i.decide ? '0 : idx_q + rlsc_pkg::AW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && kept) text_mem[text_len_q[rlsc_pkg::AW-1:0]] <= in_char_i;
    if (put && code_room) code_mem[code_len_q[rlsc_pkg::AW-1:0]] <= put_data;
    text_rd_q <= text_mem[raddr];
    code_rd_q <= code_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_len_q  <= '0;
      code_len_q  <= '0;
      run_ch_q    <= '0;
      run_cnt_q   <= '0;
      run_open_q  <= 1'b0;
      pend_ch_q   <= '0;
      pend_new_q  <= 1'b0;
      pend_last_q <= 1'b0;
      sel_code_q  <= 1'b0;
      out_len_q   <= '0;
      idx_q       <= '0;
    end else begin
      if (cmd_i.load) begin
        pend_ch_q   <= in_char_i;
        pend_last_q <= in_last_i;
        pend_new_q  <= stat_o.brk;
        if (kept) begin
          text_len_q <= text_len_q + rlsc_pkg::TLW'(1);
          if (same) begin
            run_cnt_q <= run_cnt_q + rlsc_pkg::TLW'(1);
          end else if (!run_open_q) begin
            run_ch_q   <= in_char_i;
            run_cnt_q  <= rlsc_pkg::TLW'(1);
            run_open_q <= 1'b1;
          end
        end
      end
      if (put) code_len_q <= code_len_q + rlsc_pkg::CLW'(1);
      // open the held run once the previous one is written out
      if (cmd_i.put_ones && pend_new_q) begin
        run_ch_q   <= pend_ch_q;
        run_cnt_q  <= rlsc_pkg::TLW'(1);
        pend_new_q <= 1'b0;
      end
      if (cmd_i.decide) begin
        sel_code_q <= (code_len_q < {1'b0, text_len_q});
        out_len_q  <= (code_len_q < {1'b0, text_len_q}) ?
                      code_len_q[rlsc_pkg::TLW-1:0] : text_len_q;
        idx_q      <= '0;
      end
      if (cmd_i.emit) begin
        idx_q <= idx_q + rlsc_pkg::AW'(1);
        if (stat_o.emit_last) begin
          text_len_q <= '0;
          code_len_q <= '0;
          run_ch_q   <= '0;
          run_cnt_q  <= '0;
          run_open_q <= 1'b0;
        end
      end
    end
  end

  assign out_char_o = sel_code_q ? code_rd_q : text_rd_q;
  assign out_last_o = cmd_i.emit && stat_o.emit_last;

endmodule
